// ===== hdl/rrol_pkg.sv =====
package rrol_pkg;

   localparam int TAG_W      = 32;
   localparam int REQ_LEN_W  = 16;
   localparam int OFF_W      = 20;
   localparam int RSP_SLOT_W = 4;
   localparam int RSP_OFF_W  = 16;

   // Two entries let the front take up to two more items while the back is walking.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_FIND = 1'b1
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [TAG_W-1:0]     tag;
      logic [REQ_LEN_W-1:0] length;
      logic [OFF_W-1:0]     offset;
   } cmd_type;

   typedef struct packed {
      logic                  found;
      logic [RSP_SLOT_W-1:0] slot_index;
      logic [TAG_W-1:0]      found_tag;
      logic [RSP_OFF_W-1:0]  offset_in_record;
      logic                  overwrote_oldest;
   } rsp_type;

endpackage

// ===== hdl/rrol_front.sv =====
module rrol_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [rrol_pkg::TAG_W-1:0]          req_record_tag,
   input  logic [rrol_pkg::REQ_LEN_W-1:0]      req_record_length,
   input  logic [rrol_pkg::OFF_W-1:0]          req_byte_offset,
   output logic                                cmd_valid,
   output rrol_pkg::cmd_type                   cmd,
   input  logic                                cmd_pop
);

   rrol_pkg::cmd_type q_ff [rrol_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   rrol_pkg::cmd_type cmd_new;

   assign busy      = (count_ff == 2'(rrol_pkg::QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // Classify the item; fields an operation ignores are dropped here.
   always_comb begin
      cmd_new.op     = rrol_pkg::op_type'(req_opcode);
      cmd_new.tag    = '0;
      cmd_new.length = '0;
      cmd_new.offset = '0;
      case (cmd_new.op)
         rrol_pkg::OP_ADD: begin
            cmd_new.tag    = req_record_tag;
            cmd_new.length = req_record_length;
         end
         rrol_pkg::OP_FIND: begin
            cmd_new.offset = req_byte_offset;
         end
         default: begin
            cmd_new.offset = '0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== hdl/rrol_back.sv =====
module rrol_back #(
   parameter int SLOTS       = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  rrol_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_strobe,
   output rrol_pkg::rsp_type rsp
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (LENGTH_BITS > rrol_pkg::OFF_W) ? LENGTH_BITS : rrol_pkg::OFF_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      if (s == LAST_SLOT) begin
         next_slot = '0;
      end else begin
         next_slot = s + SLOT_W'(1);
      end
   endfunction

   function automatic logic [rrol_pkg::RSP_SLOT_W-1:0] rsp_slot(input logic [SLOT_W-1:0] s);
      logic [31:0] wide;
      wide     = 32'(s);
      rsp_slot = wide[rrol_pkg::RSP_SLOT_W-1:0];
   endfunction

   logic [rrol_pkg::TAG_W-1:0] tag_mem_ff [SLOTS];
   logic [LENGTH_BITS-1:0]     len_mem_ff [SLOTS];
   logic [rrol_pkg::TAG_W-1:0] tag_rd_ff;
   logic [LENGTH_BITS-1:0]     len_rd_ff;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]     read_slot_ff, read_slot_in;
   logic                  full_ff, full_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [rrol_pkg::OFF_W-1:0] off_ff, off_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rrol_pkg::rsp_type     rsp_ff, rsp_in;

   logic [SLOT_W-1:0]     rd_addr;
   logic                  mem_we;
   logic [CNT_W-1:0]      occupancy;
   logic [CMP_W-1:0]      off_x, len_x, diff;
   logic [SLOT_W-1:0]     ws_next, rs_next;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // The walk fetches the next descriptor while the current one is tested.
   assign rd_addr = (state_ff == ST_WALK) ? next_slot(idx_ff) : read_slot_ff;

   assign off_x = CMP_W'(off_ff);
   assign len_x = CMP_W'(len_rd_ff);
   assign diff  = off_x - len_x;

   assign ws_next = next_slot(write_slot_ff);
   assign rs_next = full_ff ? next_slot(read_slot_ff) : read_slot_ff;

   always_comb begin
      if (full_ff) begin
         occupancy = CNT_W'(SLOTS);
      end else if (write_slot_ff >= read_slot_ff) begin
         occupancy = CNT_W'(write_slot_ff) - CNT_W'(read_slot_ff);
      end else begin
         occupancy = CNT_W'(write_slot_ff) + CNT_W'(SLOTS) - CNT_W'(read_slot_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      full_in       = full_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      off_in        = off_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == rrol_pkg::OP_ADD) begin
                  mem_we        = 1'b1;
                  write_slot_in = ws_next;
                  read_slot_in  = rs_next;
                  if (ws_next == rs_next) begin
                     full_in = 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.slot_index       = rsp_slot(write_slot_ff);
                  rsp_in.overwrote_oldest = full_ff;
               end else begin
                  idx_in   = read_slot_ff;
                  cnt_in   = occupancy;
                  off_in   = cmd.offset;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (cnt_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               state_in      = ST_IDLE;
            end else if (off_x < len_x) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               rsp_in.found            = 1'b1;
               rsp_in.slot_index       = rsp_slot(idx_ff);
               rsp_in.found_tag        = tag_rd_ff;
               rsp_in.offset_in_record = off_ff[rrol_pkg::RSP_OFF_W-1:0];
               state_in = ST_IDLE;
            end else begin
               // Offset is at least the length here, so the difference fits.
               off_in = diff[rrol_pkg::OFF_W-1:0];
               idx_in = next_slot(idx_ff);
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         full_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         full_ff       <= full_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem_ff[write_slot_ff] <= cmd.tag;
         len_mem_ff[write_slot_ff] <= LENGTH_BITS'(cmd.length);
      end
      tag_rd_ff <= tag_mem_ff[rd_addr];
      len_rd_ff <= len_mem_ff[rd_addr];
   end

endmodule

// ===== hdl/record_ring_with_offset_lookup.sv =====
// Channel   Direction  Ports                                   Transfer
// request   in         start, busy, req_*                      start high, busy low
// result    out        rsp_strobe, rsp_*                       one cycle, rsp_strobe high
//
// An add is finished in the execution unit when it is taken; a find is taken, then the walk
// passes the stored records one at a time, and then it decides on a match or none; the single
// descriptor memory read port sets this.
// The result strobe is registered: it rises in the cycle after the execution unit finishes an item.
// A two-entry queue sits between intake and execution; busy is high while it is full.
// Synchronous reset empties the ring and the queue; descriptor contents are not cleared.
// Results cannot be held off by the receiver.
module record_ring_with_offset_lookup #(
   parameter int SLOTS       = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [rrol_pkg::TAG_W-1:0]          req_record_tag,
   input  logic [rrol_pkg::REQ_LEN_W-1:0]      req_record_length,
   input  logic [rrol_pkg::OFF_W-1:0]          req_byte_offset,
   output logic                                rsp_strobe,
   output logic                                rsp_found,
   output logic [rrol_pkg::RSP_SLOT_W-1:0]     rsp_slot_index,
   output logic [rrol_pkg::TAG_W-1:0]          rsp_found_tag,
   output logic [rrol_pkg::RSP_OFF_W-1:0]      rsp_offset_in_record,
   output logic                                rsp_overwrote_oldest
);

   logic              cmd_valid;
   logic              cmd_pop;
   rrol_pkg::cmd_type cmd;
   rrol_pkg::rsp_type rsp;

   rrol_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_record_tag    (req_record_tag),
      .req_record_length (req_record_length),
      .req_byte_offset   (req_byte_offset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   rrol_back #(
      .SLOTS       (SLOTS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_found            = rsp.found;
   assign rsp_slot_index       = rsp.slot_index;
   assign rsp_found_tag        = rsp.found_tag;
   assign rsp_offset_in_record = rsp.offset_in_record;
   assign rsp_overwrote_oldest = rsp.overwrote_oldest;

endmodule

// ===== sim/record_ring_with_offset_lookup_test.sv =====
module record_ring_with_offset_lookup_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS  = 16;
   localparam int ITEM_COUNT  = 750;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      rrol_pkg::op_type           op;
      logic [rrol_pkg::TAG_W-1:0] tag;
      logic [15:0]                length;
      logic [rrol_pkg::OFF_W-1:0] offset;
      bit                         known;
      rrol_pkg::rsp_type          rsp;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic                            req_opcode;
   logic [rrol_pkg::TAG_W-1:0]      req_record_tag;
   logic [rrol_pkg::REQ_LEN_W-1:0]  req_record_length;
   logic [rrol_pkg::OFF_W-1:0]      req_byte_offset;
   logic                            rsp_strobe;
   logic                            rsp_found;
   logic [rrol_pkg::RSP_SLOT_W-1:0] rsp_slot_index;
   logic [rrol_pkg::TAG_W-1:0]      rsp_found_tag;
   logic [rrol_pkg::RSP_OFF_W-1:0]  rsp_offset_in_record;
   logic                            rsp_overwrote_oldest;

   // Descriptor ring as the testbench expects it to be.
   logic [rrol_pkg::TAG_W-1:0] ring_tag [RING_SLOTS];
   logic [15:0]                ring_len [RING_SLOTS];
   logic [3:0]                 wr_slot;
   logic [3:0]                 rd_slot;
   bit                         ring_is_full;

   rrol_pkg::rsp_type awaited_responses [$];
   stim_row_type      directed_rows [$];
   bit                row_known;
   rrol_pkg::rsp_type row_rsp;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   localparam rrol_pkg::rsp_type NO_MATCH = '0;

   record_ring_with_offset_lookup #(
      .SLOTS      (RING_SLOTS),
      .LENGTH_BITS(16)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_record_tag      (req_record_tag),
      .req_record_length   (req_record_length),
      .req_byte_offset     (req_byte_offset),
      .rsp_strobe          (rsp_strobe),
      .rsp_found           (rsp_found),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_found_tag       (rsp_found_tag),
      .rsp_offset_in_record(rsp_offset_in_record),
      .rsp_overwrote_oldest(rsp_overwrote_oldest)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rrol_pkg::rsp_type add_done(logic [3:0] slot, bit overwrote);
      rrol_pkg::rsp_type r;
      r = '0;
      r.slot_index = slot;
      r.overwrote_oldest = overwrote;
      return r;
   endfunction

   // Applies one item to the expected ring and returns the result it must produce.
   function automatic rrol_pkg::rsp_type append_or_locate(rrol_pkg::op_type op,
                                                          logic [rrol_pkg::TAG_W-1:0] tag,
                                                          logic [15:0] length,
                                                          logic [rrol_pkg::OFF_W-1:0] offset);
      rrol_pkg::rsp_type r;
      bit                was_full;
      logic [3:0]        span;
      logic [3:0]        idx;
      int                count;
      int                remaining;
      r = '0;
      if (op == rrol_pkg::OP_ADD) begin
         was_full = ring_is_full;
         if (was_full) rd_slot = rd_slot + 4'd1;
         ring_tag[wr_slot] = tag;
         ring_len[wr_slot] = length;
         r = add_done(wr_slot, was_full);
         wr_slot = wr_slot + 4'd1;
         if (wr_slot == rd_slot) ring_is_full = 1'b1;
      end else begin
         span = wr_slot - rd_slot;
         count = ring_is_full ? RING_SLOTS : int'(span);
         idx = rd_slot;
         remaining = int'(offset);
         for (int i = 0; i < count; i++) begin
            // Zero-length records never match and cost nothing from the offset.
            if (remaining < int'(ring_len[idx])) begin
               r.found = 1'b1;
               r.slot_index = idx;
               r.found_tag = ring_tag[idx];
               r.offset_in_record = remaining[15:0];
               break;
            end
            remaining -= int'(ring_len[idx]);
            idx = idx + 4'd1;
         end
      end
      return r;
   endfunction

   function automatic int stored_bytes();
      logic [3:0] span;
      int         count;
      int         total;
      span = wr_slot - rd_slot;
      count = ring_is_full ? RING_SLOTS : int'(span);
      total = 0;
      for (int i = 0; i < count; i++) total += int'(ring_len[rd_slot + i[3:0]]);
      return total;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Results are checked before the item accepted at the same edge is queued.
   always @(posedge clock) begin
      rrol_pkg::rsp_type want;
      rrol_pkg::rsp_type pred;
      if (!reset && rsp_strobe) begin
         if (awaited_responses.size() == 0) begin
            $error("result strobe with no item outstanding");
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("found", 32'(want.found), 32'(rsp_found));
            check_field("slot_index", 32'(want.slot_index), 32'(rsp_slot_index));
            check_field("found_tag", want.found_tag, rsp_found_tag);
            check_field("offset_in_record", 32'(want.offset_in_record),
                        32'(rsp_offset_in_record));
            check_field("overwrote_oldest", 32'(want.overwrote_oldest),
                        32'(rsp_overwrote_oldest));
         end
      end
      if (!reset && start && !busy) begin
         pred = append_or_locate(rrol_pkg::op_type'(req_opcode), req_record_tag,
                                 req_record_length, req_byte_offset);
         awaited_responses.push_back(row_known ? row_rsp : pred);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(rrol_pkg::op_type op, logic [rrol_pkg::TAG_W-1:0] tag,
                            logic [15:0] length, logic [rrol_pkg::OFF_W-1:0] offset,
                            bit known, rrol_pkg::rsp_type rsp);
      req_opcode = op;
      req_record_tag = tag;
      req_record_length = length;
      req_byte_offset = offset;
      row_known = known;
      row_rsp = rsp;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_for(int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (awaited_responses.size() != 0) @(negedge clock);
   endtask

   initial begin
      int               pick;
      int               total;
      rrol_pkg::op_type op;
      logic [15:0]      length;
      logic [19:0]      offset;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = rrol_pkg::OP_ADD;
      req_record_tag = '0;
      req_record_length = '0;
      req_byte_offset = '0;
      row_known = 1'b0;
      row_rsp = '0;
      wr_slot = '0;
      rd_slot = '0;
      ring_is_full = 1'b0;
      foreach (ring_tag[i]) begin
         ring_tag[i] = '0;
         ring_len[i] = '0;
      end

      // Empty ring, extreme records, zero-length skip, fill and first overwrite.
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'h00000, 1'b1, NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'hFFFFF, 1'b1, NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_ADD, 32'h0, 16'h0000, 20'h0, 1'b1,
                                add_done(4'd0, 1'b0)});
      directed_rows.push_back('{rrol_pkg::OP_ADD, 32'hFFFFFFFF, 16'hFFFF, 20'hFFFFF, 1'b1,
                                add_done(4'd1, 1'b0)});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'hFFFFFFFF, 16'hFFFF, 20'h00000, 1'b0,
                                NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'h0FFFE, 1'b0, NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'h0FFFF, 1'b1, NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_ADD, 32'h12345678, 16'h0001, 20'h0, 1'b1,
                                add_done(4'd2, 1'b0)});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'h0FFFF, 1'b0, NO_MATCH});
      for (int s = 3; s < RING_SLOTS; s++)
         directed_rows.push_back('{rrol_pkg::OP_ADD, 32'hA5A50000 + s, 16'hFFFF, 20'h0, 1'b0,
                                   NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_ADD, 32'hDEADBEEF, 16'h0003, 20'h0, 1'b1,
                                add_done(4'd0, 1'b1)});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'hDFFF5, 1'b0, NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'hDFFF6, 1'b0, NO_MATCH});
      directed_rows.push_back('{rrol_pkg::OP_FIND, 32'h0, 16'h0, 20'hFFFFF, 1'b1, NO_MATCH});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].tag, directed_rows[i].length,
                   directed_rows[i].offset, directed_rows[i].known, directed_rows[i].rsp);
         if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 3));
      end
      drain();

      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (n == ITEM_COUNT / 2) drain();
         pick = $urandom_range(0, 99);
         if (pick >= 92) idle_for($urandom_range(10, 40));
         else if (pick >= 70) idle_for($urandom_range(1, 3));

         op = ($urandom_range(0, 99) < 45) ? rrol_pkg::OP_ADD : rrol_pkg::OP_FIND;
         pick = $urandom_range(0, 99);
         if (pick < 20) length = 16'h0000;
         else if (pick < 55) length = 16'($urandom_range(1, 8));
         else if (pick < 65) length = 16'hFFFF;
         else length = 16'($urandom_range(0, 16'hFFFF));

         total = stored_bytes();
         pick = $urandom_range(0, 99);
         if (pick < 60 && total > 0) offset = 20'($urandom_range(0, total - 1));
         else if (pick < 75) offset = 20'(total + $urandom_range(0, 2));
         else if (pick < 90) offset = 20'($urandom_range(0, 20'hFFFFF));
         else offset = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;

         send_item(op, $urandom, length, offset, 1'b0, NO_MATCH);
      end

      drain();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== record_ring_with_offset_lookup.f =====
hdl/rrol_pkg.sv
hdl/rrol_front.sv
hdl/rrol_back.sv
hdl/record_ring_with_offset_lookup.sv
sim/record_ring_with_offset_lookup_test.sv
